### rtl/core/cpfm_pkg.sv
package cpfm_pkg;

  // Sizing
  localparam int NUM_CHANNELS = 4;
  localparam int COUNT_BITS   = 16;
  localparam int CH_W         = 2;
  localparam int CH_IDX_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int FREQ_W       = 24;
  localparam int LIMIT_W      = 16;
  localparam int CAP_W        = 16;
  localparam int PERIOD_W     = 16;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 24;
  localparam int DIV_CNT_W    = $clog2(FREQ_W);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TICK_RATE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_FREQUENCY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_HIGH    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_LOW     = 2'd3;

  // Reset values
  localparam logic [FREQ_W-1:0]  TICK_RATE_RST     = 24'd1000000;
  localparam logic [FREQ_W-1:0]  MIN_FREQUENCY_RST = 24'd100;
  localparam logic [LIMIT_W-1:0] LIMIT_HIGH_RST    = 16'd500;
  localparam logic [LIMIT_W-1:0] LIMIT_LOW_RST     = 16'd50;

  // Divider request
  typedef struct packed {
    logic                start;
    logic [FREQ_W-1:0]   dividend;
    logic [PERIOD_W-1:0] divisor;
  } div_ctl_t;

  // Divider result
  typedef struct packed {
    logic              done;
    logic [FREQ_W-1:0] quotient;
  } div_res_t;

endpackage

### rtl/core/cpfm_if.sv
// Capture request channel
interface cpfm_in_if;
  logic                        valid;
  logic                        ready;
  logic [cpfm_pkg::CH_W-1:0]   channel;
  logic [cpfm_pkg::CAP_W-1:0]  capture_value;

  modport source (output valid, output channel, output capture_value, input ready);
  modport sink   (input valid, input channel, input capture_value, output ready);
endinterface

// Measurement result channel
interface cpfm_out_if;
  logic                          valid;
  logic                          ready;
  logic [cpfm_pkg::CH_W-1:0]     out_channel;
  logic                          measured;
  logic [cpfm_pkg::PERIOD_W-1:0] period_ticks;
  logic [cpfm_pkg::FREQ_W-1:0]   frequency;
  logic [cpfm_pkg::LIMIT_W-1:0]  limited_frequency;

  modport source (output valid, output out_channel, output measured, output period_ticks,
                  output frequency, output limited_frequency, input ready);
  modport sink   (input valid, input out_channel, input measured, input period_ticks,
                  input frequency, input limited_frequency, output ready);
endinterface

### rtl/core/cpfm_div.sv
// Restoring divider, one quotient bit per cycle
module cpfm_div (
  input  logic                clk,
  input  logic                rst_n,
  input  cpfm_pkg::div_ctl_t  ctl,
  output cpfm_pkg::div_res_t  res
);

  logic [cpfm_pkg::FREQ_W-1:0]    quo_r, quo_nxt;
  logic [cpfm_pkg::PERIOD_W-1:0]  rem_r, rem_nxt;
  logic [cpfm_pkg::PERIOD_W-1:0]  dvs_r, dvs_nxt;
  logic [cpfm_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                           busy_r, busy_nxt;
  logic                           done_r, done_nxt;
  logic [cpfm_pkg::PERIOD_W:0]    shifted;
  logic [cpfm_pkg::PERIOD_W:0]    trial;
  logic                           fits;

  // One shift-subtract step
  always_comb begin
    shifted = {rem_r, quo_r[cpfm_pkg::FREQ_W-1]};
    trial   = shifted - {1'b0, dvs_r};
    fits    = (shifted >= {1'b0, dvs_r});
  end

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (ctl.start) begin
      quo_nxt  = ctl.dividend;
      rem_nxt  = '0;
      dvs_nxt  = ctl.divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt = {quo_r[cpfm_pkg::FREQ_W-2:0], fits};
      rem_nxt = fits ? trial[cpfm_pkg::PERIOD_W-1:0] : shifted[cpfm_pkg::PERIOD_W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == cpfm_pkg::DIV_CNT_W'(cpfm_pkg::FREQ_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign res.done     = done_r;
  assign res.quotient = quo_r;

endmodule

### rtl/core/capture_pair_frequency_meter.sv
// Capture-pair frequency meter. Each request is one capture edge (channel and
// latched timer count). The first edge on a channel stores its count and arms
// the channel; the second disarms it, derives the period from the two counts
// (wrap-around handled, a zero or equal period taken as one tick) and divides
// tick_rate by it to give the channel's new frequency, stored as zero when
// below min_frequency. Every edge returns one result: the channel's stored
// frequency and a copy clamped to limit_high, reading zero below limit_low.
// Per-channel counts and frequencies sit in small memories with one write port
// and one registered read port. An arming edge goes through the memory read to
// its result; a completing edge also waits on the bit-serial divider.
// One edge is in flight at a time; a waiting result sits in the output register
// while the next edge is accepted. Registers may only be written while idle.
module capture_pair_frequency_meter (
  input  logic                                clk,
  input  logic                                rst_n,
  cpfm_in_if.sink                             in_chan,
  cpfm_out_if.source                          out_chan,
  input  logic                                cfg_wr_en,
  input  logic [cpfm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cpfm_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_DONE = 3'd3;

  localparam int NCH = cpfm_pkg::NUM_CHANNELS;
  localparam int IW  = cpfm_pkg::CH_IDX_W;
  localparam int CB  = cpfm_pkg::COUNT_BITS;
  localparam int FW  = cpfm_pkg::FREQ_W;
  localparam int LW  = cpfm_pkg::LIMIT_W;
  localparam int PW  = cpfm_pkg::PERIOD_W;

  // Configuration registers
  logic [FW-1:0] tick_rate_r, min_frequency_r;
  logic [LW-1:0] limit_high_r, limit_low_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_rate_r     <= cpfm_pkg::TICK_RATE_RST;
      min_frequency_r <= cpfm_pkg::MIN_FREQUENCY_RST;
      limit_high_r    <= cpfm_pkg::LIMIT_HIGH_RST;
      limit_low_r     <= cpfm_pkg::LIMIT_LOW_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        cpfm_pkg::REG_TICK_RATE:     tick_rate_r     <= cfg_wdata[FW-1:0];
        cpfm_pkg::REG_MIN_FREQUENCY: min_frequency_r <= cfg_wdata[FW-1:0];
        cpfm_pkg::REG_LIMIT_HIGH:    limit_high_r    <= cfg_wdata[LW-1:0];
        cpfm_pkg::REG_LIMIT_LOW:     limit_low_r     <= cfg_wdata[LW-1:0];
        default: ;
      endcase
    end
  end

  logic [2:0]    state_r, state_nxt;
  logic [cpfm_pkg::CH_W-1:0] ch_r, ch_nxt;
  logic          in_range_r, in_range_nxt;
  logic [CB-1:0] cap_r, cap_nxt;
  logic          measured_r, measured_nxt;
  logic [PW-1:0] period_r, period_nxt;
  logic [FW-1:0] freq_r, freq_nxt;
  logic [NCH-1:0] armed_r, armed_nxt;
  logic [NCH-1:0] freq_vld_r, freq_vld_nxt;

  logic          in_acc;
  logic          out_load;
  logic [IW-1:0] rd_idx;
  logic [IW-1:0] idx;

  // Per-channel memories
  logic [CB-1:0] fc_mem [NCH];
  logic [FW-1:0] fq_mem [NCH];
  logic [CB-1:0] fc_rd_r;
  logic [FW-1:0] fq_rd_r;
  logic          fc_we, fq_we;
  logic [FW-1:0] fq_wdata;

  // Divider
  cpfm_pkg::div_ctl_t div_ctl;
  cpfm_pkg::div_res_t div_res;
  logic [CB-1:0]      period_calc;
  logic [FW-1:0]      q_final;

  cpfm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (div_ctl),
    .res   (div_res)
  );

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign rd_idx        = in_chan.channel[IW-1:0];
  assign idx           = ch_r[IW-1:0];
  assign out_load      = (state_r == S_DONE) && (!out_chan.valid || out_chan.ready);

  always_ff @(posedge clk) begin
    if (fc_we) begin
      fc_mem[idx] <= cap_r;
    end
    if (fq_we) begin
      fq_mem[idx] <= fq_wdata;
    end
    fc_rd_r <= fc_mem[rd_idx];
    fq_rd_r <= fq_mem[rd_idx];
  end

  // Period from the stored and current counts
  always_comb begin
    if (cap_r > fc_rd_r) begin
      period_calc = cap_r - fc_rd_r;
    end else if (cap_r < fc_rd_r) begin
      period_calc = (cpfm_pkg::COUNT_MAX - fc_rd_r) + cap_r;
    end else begin
      period_calc = CB'(1);
    end
    if (period_calc == '0) begin
      period_calc = CB'(1);
    end
  end

  assign q_final = (div_res.quotient < min_frequency_r) ? '0 : div_res.quotient;

  // Sequencer
  always_comb begin
    state_nxt    = state_r;
    ch_nxt       = ch_r;
    in_range_nxt = in_range_r;
    cap_nxt      = cap_r;
    measured_nxt = measured_r;
    period_nxt   = period_r;
    freq_nxt     = freq_r;
    armed_nxt    = armed_r;
    freq_vld_nxt = freq_vld_r;
    fc_we        = 1'b0;
    fq_we        = 1'b0;
    fq_wdata     = q_final;
    div_ctl.start    = 1'b0;
    div_ctl.dividend = tick_rate_r;
    div_ctl.divisor  = PW'(period_calc);
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          ch_nxt       = in_chan.channel;
          in_range_nxt = (32'(in_chan.channel) < NCH);
          cap_nxt      = CB'(in_chan.capture_value);
          state_nxt    = S_READ;
        end
      end
      S_READ: begin
        measured_nxt = 1'b0;
        period_nxt   = '0;
        freq_nxt     = '0;
        if (!in_range_r) begin
          state_nxt = S_DONE;
        end else if (armed_r[idx]) begin
          armed_nxt[idx] = 1'b0;
          div_ctl.start  = 1'b1;
          period_nxt     = PW'(period_calc);
          state_nxt      = S_DIV;
        end else begin
          armed_nxt[idx] = 1'b1;
          fc_we          = 1'b1;
          freq_nxt       = freq_vld_r[idx] ? fq_rd_r : '0;
          state_nxt      = S_DONE;
        end
      end
      S_DIV: begin
        if (div_res.done) begin
          fq_we             = 1'b1;
          freq_vld_nxt[idx] = 1'b1;
          freq_nxt          = q_final;
          measured_nxt      = 1'b1;
          state_nxt         = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      armed_r    <= '0;
      freq_vld_r <= '0;
    end else begin
      state_r    <= state_nxt;
      armed_r    <= armed_nxt;
      freq_vld_r <= freq_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ch_r       <= ch_nxt;
    in_range_r <= in_range_nxt;
    cap_r      <= cap_nxt;
    measured_r <= measured_nxt;
    period_r   <= period_nxt;
    freq_r     <= freq_nxt;
  end

  // Output register with clamp
  logic                      out_valid_r, out_valid_nxt;
  logic [cpfm_pkg::CH_W-1:0] o_ch_r;
  logic                      o_meas_r;
  logic [PW-1:0]             o_period_r;
  logic [FW-1:0]             o_freq_r;
  logic [LW-1:0]             o_lim_r;
  logic [LW-1:0]             lim_calc;

  always_comb begin
    if (freq_r > FW'(limit_high_r)) begin
      lim_calc = limit_high_r;
    end else if (freq_r < FW'(limit_low_r)) begin
      lim_calc = '0;
    end else begin
      lim_calc = freq_r[LW-1:0];
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      o_ch_r     <= ch_r;
      o_meas_r   <= measured_r;
      o_period_r <= period_r;
      o_freq_r   <= freq_r;
      o_lim_r    <= lim_calc;
    end
  end

  assign out_chan.valid             = out_valid_r;
  assign out_chan.out_channel       = o_ch_r;
  assign out_chan.measured          = o_meas_r;
  assign out_chan.period_ticks      = o_period_r;
  assign out_chan.frequency         = o_freq_r;
  assign out_chan.limited_frequency = o_lim_r;

  // Checks
  a_acc_to_read: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == S_READ)
    else $error("accepted request did not move to memory read");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_res.done |-> state_r == S_DIV)
    else $error("divider finished outside division wait");

  a_measured_period: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.measured |-> out_chan.period_ticks != '0)
    else $error("measured result with zero period");

  a_unmeasured_period: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && !out_chan.measured |-> out_chan.period_ticks == '0)
    else $error("unmeasured result with non-zero period");

endmodule

### tb/sv/frequency_meter_checker.sv
`timescale 1ns / 1ps

// Watches the capture request and result channels and the register port.
// Predicts every result from its own copy of the per-channel state and compares.
module frequency_meter_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [cpfm_pkg::CH_W-1:0]       in_channel,
  input  logic [cpfm_pkg::CAP_W-1:0]      in_capture_value,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [cpfm_pkg::CH_W-1:0]       out_channel,
  input  logic                            out_measured,
  input  logic [cpfm_pkg::PERIOD_W-1:0]   out_period_ticks,
  input  logic [cpfm_pkg::FREQ_W-1:0]     out_frequency,
  input  logic [cpfm_pkg::LIMIT_W-1:0]    out_limited_frequency,
  input  logic                            cfg_wr_en,
  input  logic [cpfm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cpfm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                              mismatches,
  output int                              pending,
  output int                              readings_checked,
  output int                              pairs_checked
);

  typedef struct packed {
    logic [cpfm_pkg::CH_W-1:0]     channel;
    logic                          measured;
    logic [cpfm_pkg::PERIOD_W-1:0] period;
    logic [cpfm_pkg::FREQ_W-1:0]   frequency;
    logic [cpfm_pkg::LIMIT_W-1:0]  limited;
  } meter_reading_t;

  // Shadow registers
  logic [cpfm_pkg::FREQ_W-1:0]  tick_rate;
  logic [cpfm_pkg::FREQ_W-1:0]  min_frequency;
  logic [cpfm_pkg::LIMIT_W-1:0] limit_high;
  logic [cpfm_pkg::LIMIT_W-1:0] limit_low;

  // Per-channel state
  logic                         armed       [cpfm_pkg::NUM_CHANNELS];
  logic [cpfm_pkg::CAP_W-1:0]   first_count [cpfm_pkg::NUM_CHANNELS];
  logic [cpfm_pkg::FREQ_W-1:0]  stored_freq [cpfm_pkg::NUM_CHANNELS];

  meter_reading_t expected_readings[$];

  // One capture edge: arm, or complete the pair and divide
  function automatic meter_reading_t measure_edge(
      input logic [cpfm_pkg::CH_W-1:0]  ch,
      input logic [cpfm_pkg::CAP_W-1:0] cap);
    logic [31:0]                 span;
    logic [cpfm_pkg::FREQ_W-1:0] quotient;
    meter_reading_t              r;
    r = '0;
    r.channel = ch;
    if (ch < cpfm_pkg::NUM_CHANNELS) begin
      if (!armed[ch]) begin
        armed[ch] = 1'b1;
        first_count[ch] = cap;
      end else begin
        armed[ch] = 1'b0;
        if (cap > first_count[ch]) begin
          span = 32'(cap) - 32'(first_count[ch]);
        end else if (cap < first_count[ch]) begin
          // wrapped count: formula keeps the off-by-one of the original
          span = (32'(cpfm_pkg::COUNT_MAX) - 32'(first_count[ch])) + 32'(cap);
        end else begin
          span = 32'd1;
        end
        if (span == 0) span = 32'd1;
        quotient = cpfm_pkg::FREQ_W'(32'(tick_rate) / span);
        if (quotient < min_frequency) quotient = '0;
        stored_freq[ch] = quotient;
        r.measured = 1'b1;
        r.period = span[cpfm_pkg::PERIOD_W-1:0];
      end
      r.frequency = stored_freq[ch];
      // upper clamp takes precedence over the lower cut-off
      if (r.frequency > limit_high) r.limited = limit_high;
      else if (r.frequency < limit_low) r.limited = '0;
      else r.limited = r.frequency[cpfm_pkg::LIMIT_W-1:0];
    end
    return r;
  endfunction

  always @(posedge clk) begin : track
    meter_reading_t got;
    meter_reading_t want;
    if (!rst_n) begin
      tick_rate     = cpfm_pkg::TICK_RATE_RST;
      min_frequency = cpfm_pkg::MIN_FREQUENCY_RST;
      limit_high    = cpfm_pkg::LIMIT_HIGH_RST;
      limit_low     = cpfm_pkg::LIMIT_LOW_RST;
      for (int i = 0; i < cpfm_pkg::NUM_CHANNELS; i++) begin
        armed[i]       = 1'b0;
        first_count[i] = '0;
        stored_freq[i] = '0;
      end
      expected_readings.delete();
      mismatches       <= 0;
      readings_checked <= 0;
      pairs_checked    <= 0;
    end else begin
      // register writes, masked to each register's width
      if (cfg_wr_en) begin
        case (cfg_index)
          cpfm_pkg::REG_TICK_RATE:     tick_rate     = cfg_wdata[cpfm_pkg::FREQ_W-1:0];
          cpfm_pkg::REG_MIN_FREQUENCY: min_frequency = cfg_wdata[cpfm_pkg::FREQ_W-1:0];
          cpfm_pkg::REG_LIMIT_HIGH:    limit_high    = cfg_wdata[cpfm_pkg::LIMIT_W-1:0];
          cpfm_pkg::REG_LIMIT_LOW:     limit_low     = cfg_wdata[cpfm_pkg::LIMIT_W-1:0];
          default: ;
        endcase
      end

      // result accepted: compare with the oldest prediction
      if (out_valid && out_ready) begin
        got.channel   = out_channel;
        got.measured  = out_measured;
        got.period    = out_period_ticks;
        got.frequency = out_frequency;
        got.limited   = out_limited_frequency;
        readings_checked <= readings_checked + 1;
        if (got.measured) pairs_checked <= pairs_checked + 1;
        if (expected_readings.size() == 0) begin
          if (mismatches < 10)
            $display("Unexpected result: ch=%0d meas=%0d period=%0d freq=%0d lim=%0d",
                     got.channel, got.measured, got.period, got.frequency, got.limited);
          mismatches <= mismatches + 1;
        end else begin
          want = expected_readings.pop_front();
          if (got !== want) begin
            if (mismatches < 10) begin
              $display("Result %0d mismatch", readings_checked);
              $display("  expected ch=%0d meas=%0d period=%0d freq=%0d lim=%0d",
                       want.channel, want.measured, want.period, want.frequency,
                       want.limited);
              $display("  actual   ch=%0d meas=%0d period=%0d freq=%0d lim=%0d",
                       got.channel, got.measured, got.period, got.frequency, got.limited);
            end
            mismatches <= mismatches + 1;
          end
        end
      end

      // capture request accepted: predict its result
      if (in_valid && in_ready)
        expected_readings.push_back(measure_edge(in_channel, in_capture_value));
    end
    pending <= expected_readings.size();
  end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int WATCHDOG_LIMIT   = 4000;
  localparam int HOLDOFF_CYCLES   = 300;
  localparam int SETTLE_CYCLES    = 40;
  localparam int PHASES           = 8;
  localparam int RANDOM_PER_PHASE = 229;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                            cfg_wr_en;
  logic [cpfm_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [cpfm_pkg::CFG_DATA_W-1:0] cfg_wdata;

  int sender_gap_pct     = 0;
  int receiver_stall_pct = 0;
  int holdoff_asked      = 0;
  int idle_cycles        = 0;

  int mismatches;
  int pending;
  int readings_checked;
  int pairs_checked;

  cpfm_in_if  in_chan ();
  cpfm_out_if out_chan ();

  capture_pair_frequency_meter uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  frequency_meter_checker meter_check (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_chan.valid),
    .in_ready              (in_chan.ready),
    .in_channel            (in_chan.channel),
    .in_capture_value      (in_chan.capture_value),
    .out_valid             (out_chan.valid),
    .out_ready             (out_chan.ready),
    .out_channel           (out_chan.out_channel),
    .out_measured          (out_chan.measured),
    .out_period_ticks      (out_chan.period_ticks),
    .out_frequency         (out_chan.frequency),
    .out_limited_frequency (out_chan.limited_frequency),
    .cfg_wr_en             (cfg_wr_en),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata),
    .mismatches            (mismatches),
    .pending               (pending),
    .readings_checked      (readings_checked),
    .pairs_checked         (pairs_checked)
  );

  always #2 clk = ~clk;

  // Result side: random stalls, plus a long hold-off when asked for
  initial begin : result_receiver
    int holdoff_served;
    int stall_left;
    holdoff_served = 0;
    stall_left = 0;
    out_chan.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (holdoff_asked != holdoff_served) begin
        holdoff_served = holdoff_asked;
        stall_left = HOLDOFF_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
    end
  end

  // Watchdog on cycles with no request or result moving
  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: nothing moved for %0d cycles", idle_cycles);
      $display("Verification failed");
      $finish;
    end
  end

  // Offer one capture request, with a random gap before it
  task automatic send_edge(input logic [cpfm_pkg::CH_W-1:0]  ch,
                           input logic [cpfm_pkg::CAP_W-1:0] cap);
    while ($urandom_range(99) < sender_gap_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid         <= 1'b1;
    in_chan.channel       <= ch;
    in_chan.capture_value <= cap;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  task automatic send_pair(input logic [cpfm_pkg::CH_W-1:0]  ch,
                           input logic [cpfm_pkg::CAP_W-1:0] first,
                           input logic [cpfm_pkg::CAP_W-1:0] second);
    send_edge(ch, first);
    send_edge(ch, second);
  endtask

  // Stop offering and wait until every predicted result has come back
  task automatic wait_results_drained();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // All four registers; junk in the unused upper bits of the 16-bit ones
  task automatic load_settings(input logic [cpfm_pkg::FREQ_W-1:0]  rate,
                               input logic [cpfm_pkg::FREQ_W-1:0]  min_f,
                               input logic [cpfm_pkg::LIMIT_W-1:0] hi,
                               input logic [cpfm_pkg::LIMIT_W-1:0] lo);
    cfg_wr_en <= 1'b1;
    cfg_index <= cpfm_pkg::REG_TICK_RATE;
    cfg_wdata <= rate;
    @(posedge clk);
    cfg_index <= cpfm_pkg::REG_MIN_FREQUENCY;
    cfg_wdata <= min_f;
    @(posedge clk);
    cfg_index <= cpfm_pkg::REG_LIMIT_HIGH;
    cfg_wdata <= {8'($urandom), hi};
    @(posedge clk);
    cfg_index <= cpfm_pkg::REG_LIMIT_LOW;
    cfg_wdata <= {8'($urandom), lo};
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin : stimulus
    logic [cpfm_pkg::CAP_W-1:0] last_cap [cpfm_pkg::NUM_CHANNELS];
    logic [cpfm_pkg::CAP_W-1:0] cap;
    logic [cpfm_pkg::CH_W-1:0]  ch;
    int                         pick;

    in_chan.valid         = 1'b0;
    in_chan.channel       = '0;
    in_chan.capture_value = '0;
    cfg_wr_en             = 1'b0;
    cfg_index             = cpfm_pkg::REG_TICK_RATE;
    cfg_wdata             = '0;
    for (int i = 0; i < cpfm_pkg::NUM_CHANNELS; i++) last_cap[i] = cpfm_pkg::CAP_W'($urandom);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed pairs on reset register values
    send_pair(2'd0, 16'd0, 16'hFFFF);      // widest period, below minimum
    send_pair(2'd1, 16'hFFFF, 16'd0);      // wrap giving zero, taken as one tick
    send_pair(2'd2, 16'd1234, 16'd1234);   // equal counts
    send_pair(2'd3, 16'd40000, 16'd100);   // ordinary wrap
    send_pair(2'd0, 16'd1000, 16'd3000);   // exactly at upper clamp
    send_pair(2'd1, 16'd0, 16'd2500);      // inside the window
    send_pair(2'd2, 16'd0, 16'd19999);     // quotient below minimum
    send_pair(2'd3, 16'd0, 16'd10000);     // quotient equal to minimum
    send_pair(2'd0, 16'd0, 16'd1996);      // just above upper clamp
    wait_results_drained();

    for (int phase = 0; phase < PHASES; phase++) begin
      // register setting for this phase
      case (phase)
        0: load_settings('1, '0, '1, '0);
        1: load_settings(24'd1, '0, '0, '0);
        2: load_settings(24'd1000000, '0, 16'd60000, 16'd1000);
        3: load_settings('1, '1, '1, '1);
        4: load_settings(cpfm_pkg::TICK_RATE_RST, cpfm_pkg::MIN_FREQUENCY_RST,
                         cpfm_pkg::LIMIT_HIGH_RST, cpfm_pkg::LIMIT_LOW_RST);
        5: load_settings(cpfm_pkg::FREQ_W'($urandom_range(1, 24'hFFFFFF)),
                         cpfm_pkg::FREQ_W'($urandom_range(0, 5000)),
                         cpfm_pkg::LIMIT_W'($urandom), cpfm_pkg::LIMIT_W'($urandom));
        6: load_settings(24'd5000000, 24'd10, 16'd200, 16'd1000);
        default: load_settings(cpfm_pkg::FREQ_W'($urandom_range(1, 4000)), 24'd1, 16'd3,
                               16'd1);
      endcase

      // idling pattern: none, sender, receiver, both
      case (phase % 4)
        0: begin sender_gap_pct <= 0;  receiver_stall_pct <= 0;  end
        1: begin sender_gap_pct <= 49; receiver_stall_pct <= 0;  end
        2: begin sender_gap_pct <= 0;  receiver_stall_pct <= 49; end
        default: begin sender_gap_pct <= 36; receiver_stall_pct <= 36; end
      endcase

      // mostly realistic count progressions per channel, some noise
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (phase == 4 && n == 40) holdoff_asked <= holdoff_asked + 1;
        ch = cpfm_pkg::CH_W'($urandom_range(cpfm_pkg::NUM_CHANNELS - 1));
        pick = $urandom_range(99);
        if (pick < 40)
          cap = last_cap[ch] + cpfm_pkg::CAP_W'($urandom_range(1, 255));
        else if (pick < 65)
          cap = last_cap[ch] + cpfm_pkg::CAP_W'($urandom_range(256, 20000));
        else if (pick < 75)
          cap = last_cap[ch];
        else if (pick < 80)
          cap = last_cap[ch] - cpfm_pkg::CAP_W'(1);
        else if (pick < 85)
          cap = ($urandom_range(1) != 0) ? cpfm_pkg::COUNT_MAX : '0;
        else
          cap = cpfm_pkg::CAP_W'($urandom);
        last_cap[ch] = cap;
        send_edge(ch, cap);
      end
      wait_results_drained();
    end

    $display("Ran %0d capture requests over %0d register settings and four idling patterns;",
             readings_checked, PHASES + 1);
    $display("%0d of them completed a pair and gave a new frequency.", pairs_checked);
    if (mismatches == 0 && pending == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
